// ----- sv/ppi_pkg.sv -----
// ============================================================================
// ppi_pkg
// Shared types and constants for the path point interpolator.
// ============================================================================
package ppi_pkg;

    // Weight format: signed, W_FRAC fraction bits, saturated to +-2^SAT_LOG.
    localparam int W_FRAC  = 16;
    localparam int SAT_LOG = 2;
    localparam int QW      = W_FRAC + SAT_LOG + 1;  // unsigned quotient bits
    localparam int QCW     = $clog2(QW);
    localparam int WT_W    = QW + 1;                // signed weight
    localparam int DIFF_W  = 33;                    // b - a of two 32-bit values
    localparam int PROD_W  = DIFF_W + WT_W;
    localparam int SC_W    = PROD_W - W_FRAC;       // scaled difference
    localparam int SUM_W   = SC_W + 1;
    localparam int SEL_W   = $clog2(SAT_LOG + 1);

    localparam logic [QW-1:0] W_LIM = QW'(1) << (W_FRAC + SAT_LOG);

    localparam int NFIELDS = 7;
    localparam int NBLEND  = 6;

    // Field slots within a stored point
    localparam logic [2:0] F_X     = 3'd0;
    localparam logic [2:0] F_Y     = 3'd1;
    localparam logic [2:0] F_HEAD  = 3'd2;
    localparam logic [2:0] F_CURV  = 3'd3;
    localparam logic [2:0] F_RATE  = 3'd4;
    localparam logic [2:0] F_ACCEL = 3'd5;
    localparam logic [2:0] F_S     = 3'd6;

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Input payload, last declared field (pos_x) in the lowest bits
    typedef struct packed {
        logic signed [31:0] position_s;
        logic signed [31:0] curvature_accel;
        logic signed [31:0] curvature_rate;
        logic signed [31:0] curvature;
        logic signed [15:0] heading;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } in_payload_t;

    // Result payload, last declared field (out_x) in the lowest bits
    typedef struct packed {
        logic signed [31:0] out_s;
        logic signed [31:0] out_curvature_accel;
        logic signed [31:0] out_curvature_rate;
        logic signed [31:0] out_curvature;
        logic signed [15:0] out_heading;
        logic signed [31:0] out_y;
        logic signed [31:0] out_x;
    } out_payload_t;

endpackage

// ----- sv/path_point_interpolator_core.sv -----
// ============================================================================
// path_point_interpolator_core
// Two-point path store with linear interpolation at a queried arc position.
// ============================================================================
// The block keeps the two most recently pushed path points (x, y, heading,
// curvature, curvature rate, curvature accel, s). A push (tuser = 0) stores a
// point and produces no result. A query (tuser = 1) returns one
// result: weight w = (q - s0) / (s1 - s0) in signed Q3.16, saturated to +-4,
// x/y/curvature fields blended as a + w*(b - a) with round-half-up and
// saturation, heading blended along the shorter arc modulo 2^16, and q
// echoed as out_s. With fewer than two points held, or |s1 - s0| <= min_span,
// the older point is returned with the degenerate flag set in m_tuser.
// A query occupies the block through span setup and checks (S_SETUP, S_ABS,
// S_CHECK), a radix-2 restoring divider (one quotient bit per cycle) for the
// weight, then a multiply and an add step per field through one shared 33x20
// multiplier for the six blended fields, then the hand-off to the output
// register. A degenerate query finishes after the checks. s_tready is low
// while a query is being worked on; a finished result held in the output
// register does not block new input transfers, only the hand-off of the next
// result. min_span is written through cfg_* at any time the block is idle;
// cfg_ready is always high.
// ============================================================================
module path_point_interpolator_core (
    input  logic         aclk,
    input  logic         aresetn,

    // Configuration: min_span, unsigned Q16.0, in position_s LSBs
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,

    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] pos_x, [63:32] pos_y, [79:64] heading, [111:80] curvature,
    // [143:112] curvature_rate, [175:144] curvature_accel, [207:176] position_s
    input  logic [207:0] s_tdata,
    // [0] req_type (0 push, 1 query)
    input  logic         s_tuser,

    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] out_x, [63:32] out_y, [79:64] out_heading, [111:80] out_curvature,
    // [143:112] out_curvature_rate, [175:144] out_curvature_accel,
    // [207:176] out_s
    output logic [207:0] m_tdata,
    // [0] degenerate
    output logic         m_tuser
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;  // den = s1 - s0, num = q - s0
    localparam logic [2:0] S_ABS   = 3'd2;  // magnitudes and signs
    localparam logic [2:0] S_CHECK = 3'd3;  // degenerate / saturation test
    localparam logic [2:0] S_DIV   = 3'd4;  // one quotient bit per cycle
    localparam logic [2:0] S_MUL   = 3'd5;  // diff * w into product register
    localparam logic [2:0] S_ADD   = 3'd6;  // round, add base, saturate
    localparam logic [2:0] S_DONE  = 3'd7;  // hand off to output register

    logic [2:0] state_reg, state_next;

    // Point store: older and newer slot, one word per field
    logic [31:0] older_reg [ppi_pkg::NFIELDS];
    logic [31:0] newer_reg [ppi_pkg::NFIELDS];
    logic [1:0]  held_reg;
    logic [15:0] min_span_reg;

    // Query working registers
    logic signed [31:0]             q_reg;
    logic signed [32:0]             den_reg;
    logic signed [32:0]             num_reg;
    logic [31:0]                    aden_reg;
    logic [31:0]                    anum_reg;
    logic                           wneg_reg;
    logic                           degen_reg;
    logic                           wsat_reg;
    logic [31:0]                    rem_reg;
    logic [ppi_pkg::QW-1:0]         quo_reg;
    logic [ppi_pkg::QCW-1:0]        bit_reg;
    logic signed [ppi_pkg::WT_W-1:0]   w_reg;
    logic signed [ppi_pkg::PROD_W-1:0] prod_reg;
    logic signed [32:0]             base_reg;
    logic [2:0]                     fld_reg;
    logic [31:0]                    res_reg [ppi_pkg::NBLEND];

    // Output register
    logic         m_tvalid_reg;
    logic [207:0] m_tdata_reg;
    logic         m_tuser_reg;

    ppi_pkg::in_payload_t  in_p;
    ppi_pkg::out_payload_t out_p;
    logic [31:0]           np [ppi_pkg::NFIELDS];

    logic s_xfer, out_free;
    logic degen_c;  // span too small or fewer than two points

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign degen_c = (held_reg != 2'd2) || (aden_reg <= {16'd0, min_span_reg});

    assign in_p  = ppi_pkg::in_payload_t'(s_tdata);

    always_comb begin
        np[ppi_pkg::F_X]     = in_p.pos_x;
        np[ppi_pkg::F_Y]     = in_p.pos_y;
        np[ppi_pkg::F_HEAD]  = {16'd0, in_p.heading};
        np[ppi_pkg::F_CURV]  = in_p.curvature;
        np[ppi_pkg::F_RATE]  = in_p.curvature_rate;
        np[ppi_pkg::F_ACCEL] = in_p.curvature_accel;
        np[ppi_pkg::F_S]     = in_p.position_s;
    end

    // ---------------- divider step ----------------
    logic [ppi_pkg::QCW-1:0]   bit_off;
    logic [ppi_pkg::SEL_W-1:0] bit_sel;
    logic [ppi_pkg::SAT_LOG:0] anum_top;
    logic                      div_in;
    logic [32:0]               rem_sh;
    logic [33:0]               rem_sub;

    assign bit_off  = bit_reg - ppi_pkg::QCW'(ppi_pkg::W_FRAC);
    assign bit_sel  = bit_off[ppi_pkg::SEL_W-1:0];
    assign anum_top = anum_reg[ppi_pkg::SAT_LOG:0];
    // Dividend is anum << W_FRAC: low W_FRAC bits are zero
    assign div_in   = (bit_reg >= ppi_pkg::QCW'(ppi_pkg::W_FRAC)) ? anum_top[bit_sel] : 1'b0;
    assign rem_sh   = {rem_reg, div_in};
    assign rem_sub  = {1'b0, rem_sh} - {2'b00, aden_reg};

    // Quotient with the final bit folded in, then saturated and signed
    logic [ppi_pkg::QW-1:0]          quo_fin;
    logic [ppi_pkg::QW-1:0]          quo_sat;
    logic signed [ppi_pkg::WT_W-1:0] w_fin;

    assign quo_fin = {quo_reg[ppi_pkg::QW-2:0], !rem_sub[33]};
    assign quo_sat = (wsat_reg || quo_fin > ppi_pkg::W_LIM) ? ppi_pkg::W_LIM : quo_fin;
    assign w_fin   = wneg_reg ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});

    // ---------------- blend datapath ----------------
    logic signed [15:0]               h0, h1;
    logic signed [17:0]               hd_raw, hd_wrap;
    logic signed [32:0]               a_c, b_c, diff_c;
    logic signed [ppi_pkg::PROD_W-1:0] prod_c;
    logic signed [ppi_pkg::PROD_W-1:0] prod_rnd;
    logic signed [ppi_pkg::SC_W-1:0]   scaled;
    logic signed [ppi_pkg::SUM_W-1:0]  sum_c;
    logic [31:0]                      res_c;

    assign h0     = older_reg[ppi_pkg::F_HEAD][15:0];
    assign h1     = newer_reg[ppi_pkg::F_HEAD][15:0];
    assign hd_raw = 18'(h1) - 18'(h0);

    always_comb begin
        // Shorter arc: wrap into [-32768, 32768]
        if (hd_raw > 18'sd32768) begin
            hd_wrap = hd_raw - 18'sd65536;
        end else if (hd_raw < -18'sd32768) begin
            hd_wrap = hd_raw + 18'sd65536;
        end else begin
            hd_wrap = hd_raw;
        end
        if (fld_reg == ppi_pkg::F_HEAD) begin
            a_c    = 33'(h0);
            b_c    = 33'(h1);
            diff_c = 33'(hd_wrap);
        end else begin
            a_c    = 33'($signed(older_reg[fld_reg]));
            b_c    = 33'($signed(newer_reg[fld_reg]));
            diff_c = b_c - a_c;
        end
    end

    assign prod_c   = ppi_pkg::PROD_W'(diff_c) * ppi_pkg::PROD_W'(w_reg);
    assign prod_rnd = prod_reg + (ppi_pkg::PROD_W'(1) <<< (ppi_pkg::W_FRAC - 1));
    assign scaled   = ppi_pkg::SC_W'(prod_rnd >>> ppi_pkg::W_FRAC);
    assign sum_c    = ppi_pkg::SUM_W'(base_reg) + ppi_pkg::SUM_W'(scaled);

    always_comb begin
        if (fld_reg == ppi_pkg::F_HEAD) begin
            res_c = {16'd0, sum_c[15:0]};  // wraps modulo 2^16
        end else if (sum_c > ppi_pkg::SUM_W'(32'sh7FFF_FFFF)) begin
            res_c = 32'h7FFF_FFFF;
        end else if (sum_c < -ppi_pkg::SUM_W'(33'sh0_8000_0000)) begin
            res_c = 32'h8000_0000;
        end else begin
            res_c = sum_c[31:0];
        end
    end

    // Result word for the output register
    always_comb begin
        out_p.out_x               = res_reg[ppi_pkg::F_X];
        out_p.out_y               = res_reg[ppi_pkg::F_Y];
        out_p.out_heading         = res_reg[ppi_pkg::F_HEAD][15:0];
        out_p.out_curvature       = res_reg[ppi_pkg::F_CURV];
        out_p.out_curvature_rate  = res_reg[ppi_pkg::F_RATE];
        out_p.out_curvature_accel = res_reg[ppi_pkg::F_ACCEL];
        out_p.out_s               = q_reg;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer && s_tuser == ppi_pkg::REQ_QUERY) begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: state_next = S_ABS;
            S_ABS:   state_next = S_CHECK;
            S_CHECK: state_next = degen_c ? S_DONE : S_DIV;
            S_DIV: begin
                if (bit_reg == '0) begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_ADD;
            S_ADD: begin
                if (fld_reg == ppi_pkg::F_ACCEL) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            held_reg     <= 2'd0;
            min_span_reg <= 16'd0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < ppi_pkg::NFIELDS; i++) begin
                older_reg[i] <= 32'd0;
                newer_reg[i] <= 32'd0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                min_span_reg <= cfg_data;
            end

            // Load on hand-off, clear once the transfer is taken
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_xfer) begin
                        if (s_tuser == ppi_pkg::REQ_PUSH) begin
                            for (int i = 0; i < ppi_pkg::NFIELDS; i++) begin
                                older_reg[i] <= (held_reg == 2'd0) ? np[i] : newer_reg[i];
                                newer_reg[i] <= np[i];
                            end
                            if (held_reg != 2'd2) begin
                                held_reg <= held_reg + 2'd1;
                            end
                        end else begin
                            q_reg <= in_p.position_s;
                        end
                    end
                end
                S_SETUP: begin
                    den_reg <= 33'($signed(newer_reg[ppi_pkg::F_S]))
                             - 33'($signed(older_reg[ppi_pkg::F_S]));
                    num_reg <= 33'(q_reg) - 33'($signed(older_reg[ppi_pkg::F_S]));
                end
                S_ABS: begin
                    aden_reg <= den_reg[32] ? 32'(-den_reg) : den_reg[31:0];
                    anum_reg <= num_reg[32] ? 32'(-num_reg) : num_reg[31:0];
                    wneg_reg <= num_reg[32] != den_reg[32];
                end
                S_CHECK: begin
                    degen_reg <= degen_c;
                    // Quotient would need more than QW bits
                    wsat_reg  <= {(ppi_pkg::SAT_LOG + 1)'(0), anum_reg}
                               >= {aden_reg, (ppi_pkg::SAT_LOG + 1)'(0)};
                    rem_reg   <= anum_reg >> (ppi_pkg::SAT_LOG + 1);
                    quo_reg   <= '0;
                    bit_reg   <= ppi_pkg::QCW'(ppi_pkg::QW - 1);
                    fld_reg   <= ppi_pkg::F_X;
                    for (int i = 0; i < ppi_pkg::NBLEND; i++) begin
                        res_reg[i] <= older_reg[i];
                    end
                end
                S_DIV: begin
                    rem_reg <= rem_sub[33] ? rem_sh[31:0] : rem_sub[31:0];
                    quo_reg <= quo_fin;
                    bit_reg <= bit_reg - ppi_pkg::QCW'(1);
                    if (bit_reg == '0) begin
                        w_reg <= w_fin;
                    end
                end
                S_MUL: begin
                    prod_reg <= prod_c;
                    base_reg <= a_c;
                end
                S_ADD: begin
                    res_reg[fld_reg] <= res_c;
                    fld_reg          <= fld_reg + 3'd1;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= out_p;
                        m_tuser_reg  <= degen_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
